### src/hsvl_pkg.sv
// shared constants, types and helpers for the hsv to rgb led color converter
`timescale 1ns / 1ps

package hsvl_pkg;

  // default hue fraction width, one turn is 2**HUE_BITS
  localparam int HUE_BITS_DEF = 16;

  // fixed port widths
  localparam int HUE_W  = 16;
  localparam int SAT_W  = 9;
  localparam int BRI_W  = 9;
  localparam int BYTE_W = 8;

  // brightness after reset, 1.0 in q8
  localparam logic [BRI_W-1:0] BRI_RESET = 9'd256;

  // q8 unity for the saturation weight
  localparam logic [SAT_W:0] SAT_ONE = 10'd256;

  // number of hue sectors
  localparam int SECTORS = 6;

  // pipeline depth from transfer to result strobe
  localparam int PIPE_LAT = 6;

  // hue sector codes after the one-sector rotation
  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } sector_t;

  // advance the raw sector by one, wrapping after the last
  function automatic sector_t next_sector(logic [2:0] raw);
    sector_t s;
    case (raw)
      3'd0:    s = SEC_1;
      3'd1:    s = SEC_2;
      3'd2:    s = SEC_3;
      3'd3:    s = SEC_4;
      3'd4:    s = SEC_5;
      default: s = SEC_0;
    endcase
    return s;
  endfunction

endpackage

### src/hsvl_sector.sv
// hue sector split and brightness-scaled channel levels (two stages)
`timescale 1ns / 1ps

module hsvl_sector
  import hsvl_pkg::*;
#(
  parameter int HUE_BITS = HUE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [HUE_W-1:0]           in_hue,
  input  logic [SAT_W-1:0]           in_sat,
  input  logic [BRI_W-1:0]           brightness,
  output logic                       lvl_valid,
  output logic [HUE_BITS+BRI_W:0]    lvl_r,
  output logic [HUE_BITS+BRI_W:0]    lvl_g,
  output logic [HUE_BITS+BRI_W:0]    lvl_b,
  output logic [SAT_W-1:0]           lvl_sat
);

  localparam int HB = HUE_BITS;
  localparam int PW = HB + BRI_W + 1;
  localparam logic [HB+2:0] SIX = (HB+3)'(SECTORS);
  localparam logic [HB:0]   ONE = {1'b1, {HB{1'b0}}};

  // hue wrapped to one turn
  logic [HB+HUE_W-1:0] hue_ext;
  logic [HB-1:0]       hue_m;
  logic [HB+2:0]       x;

  assign hue_ext = {{HB{1'b0}}, in_hue};
  assign hue_m   = hue_ext[HB-1:0];
  assign x       = {3'b000, hue_m} * SIX;

  // stage a: sector and fraction
  logic          va_r;
  sector_t       sec_r, sec_nxt;
  logic [HB-1:0] f_r;
  logic [SAT_W-1:0] sat_a_r;

  assign sec_nxt = next_sector(x[HB+2:HB]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    sec_r   <= sec_nxt;
    f_r     <= x[HB-1:0];
    sat_a_r <= in_sat;
  end

  // piecewise-linear channel levels
  logic [HB:0] one_minus_f;
  logic [HB:0] f_ext;
  logic [HB:0] pr, pg, pb;

  assign f_ext       = {1'b0, f_r};
  assign one_minus_f = ONE - f_ext;

  always_comb begin
    pr = '0;
    pg = '0;
    pb = '0;
    case (sec_r)
      SEC_0: begin
        pr = ONE;
        pg = one_minus_f;
      end
      SEC_1: begin
        pr = ONE;
        pb = f_ext;
      end
      SEC_2: begin
        pr = one_minus_f;
        pb = ONE;
      end
      SEC_3: begin
        pb = ONE;
        pg = f_ext;
      end
      SEC_4: begin
        pb = one_minus_f;
        pg = ONE;
      end
      default: begin
        pg = ONE;
        pr = f_ext;
      end
    endcase
  end

  // stage b: brightness scaling
  logic          vb_r;
  logic [PW-1:0] r_r, g_r, b_r;
  logic [PW-1:0] r_nxt, g_nxt, b_nxt;
  logic [SAT_W-1:0] sat_b_r;

  assign r_nxt = PW'(pr) * PW'(brightness);
  assign g_nxt = PW'(pg) * PW'(brightness);
  assign b_nxt = PW'(pb) * PW'(brightness);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    r_r     <= r_nxt;
    g_r     <= g_nxt;
    b_r     <= b_nxt;
    sat_b_r <= sat_a_r;
  end

  assign lvl_valid = vb_r;
  assign lvl_r     = r_r;
  assign lvl_g     = g_r;
  assign lvl_b     = b_r;
  assign lvl_sat   = sat_b_r;

endmodule

### src/hsvl_blend.sv
// saturation blend of each channel with the channel sum (three stages)
`timescale 1ns / 1ps

module hsvl_blend
  import hsvl_pkg::*;
#(
  parameter int HUE_BITS = HUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              lvl_valid,
  input  logic [HUE_BITS+BRI_W:0]           lvl_r,
  input  logic [HUE_BITS+BRI_W:0]           lvl_g,
  input  logic [HUE_BITS+BRI_W:0]           lvl_b,
  input  logic [SAT_W-1:0]                  lvl_sat,
  output logic                              bl_valid,
  output logic signed [HUE_BITS+22:0]       bl_r,
  output logic signed [HUE_BITS+22:0]       bl_g,
  output logic signed [HUE_BITS+22:0]       bl_b
);

  localparam int HB = HUE_BITS;
  localparam int PW = HB + BRI_W + 1;
  localparam int SW = PW + 1;
  localparam int WW = SW + 11;
  localparam int QW = PW + SAT_W;
  localparam int BW = HB + 23;

  // stage c: channel sum and saturation weight
  logic              vc_r;
  logic [SW-1:0]     sum_r, sum_nxt;
  logic [PW-1:0]     r_c_r, g_c_r, b_c_r;
  logic [SAT_W-1:0]  sat_c_r;
  logic signed [9:0] w_r, w_nxt;

  assign sum_nxt = SW'(lvl_r) + SW'(lvl_g) + SW'(lvl_b);
  assign w_nxt   = $signed(SAT_ONE - {1'b0, lvl_sat});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else begin
      vc_r <= lvl_valid;
    end
  end

  always_ff @(posedge clk) begin
    sum_r   <= sum_nxt;
    w_r     <= w_nxt;
    r_c_r   <= lvl_r;
    g_c_r   <= lvl_g;
    b_c_r   <= lvl_b;
    sat_c_r <= lvl_sat;
  end

  // stage d: weighted products
  logic                 vd_r;
  logic [QW-1:0]        rs_r, gs_r, bs_r;
  logic [QW-1:0]        rs_nxt, gs_nxt, bs_nxt;
  logic signed [WW-1:0] ws_r, ws_nxt;

  assign rs_nxt = QW'(r_c_r) * QW'(sat_c_r);
  assign gs_nxt = QW'(g_c_r) * QW'(sat_c_r);
  assign bs_nxt = QW'(b_c_r) * QW'(sat_c_r);
  assign ws_nxt = $signed({1'b0, sum_r}) * w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else begin
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    rs_r <= rs_nxt;
    gs_r <= gs_nxt;
    bs_r <= bs_nxt;
    ws_r <= ws_nxt;
  end

  // stage e: blend sums
  logic                 ve_r;
  logic signed [BW-1:0] br_r, bg_r, bb_r;
  logic signed [BW-1:0] br_nxt, bg_nxt, bb_nxt;
  logic signed [BW-1:0] ws_ext;

  assign ws_ext = BW'(ws_r);
  assign br_nxt = $signed({{(BW-QW){1'b0}}, rs_r}) + ws_ext;
  assign bg_nxt = $signed({{(BW-QW){1'b0}}, gs_r}) + ws_ext;
  assign bb_nxt = $signed({{(BW-QW){1'b0}}, bs_r}) + ws_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else begin
      ve_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    br_r <= br_nxt;
    bg_r <= bg_nxt;
    bb_r <= bb_nxt;
  end

  assign bl_valid = ve_r;
  assign bl_r     = br_r;
  assign bl_g     = bg_r;
  assign bl_b     = bb_r;

endmodule

### src/hsvl_byte.sv
// scale by 255, floor and clamp each blend to a byte, output register
`timescale 1ns / 1ps

module hsvl_byte
  import hsvl_pkg::*;
#(
  parameter int HUE_BITS = HUE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        bl_valid,
  input  logic signed [HUE_BITS+22:0] bl_r,
  input  logic signed [HUE_BITS+22:0] bl_g,
  input  logic signed [HUE_BITS+22:0] bl_b,
  output logic                        out_valid,
  output logic [BYTE_W-1:0]           out_red,
  output logic [BYTE_W-1:0]           out_green,
  output logic [BYTE_W-1:0]           out_blue
);

  localparam int HB = HUE_BITS;
  localparam int BW = HB + 23;
  localparam int PW = BW + 7;
  localparam int SH = HB + 16;
  localparam int TW = PW - SH;
  localparam logic [TW-1:0]     BYTE_MAX_T = TW'(255);
  localparam logic [BYTE_W-1:0] BYTE_MAX   = 8'd255;

  // floor(blend * 255 / 2**(HB+16)), zero for non-positive, clamped at 255
  function automatic logic [BYTE_W-1:0] to_byte(logic signed [BW-1:0] blend);
    logic [BW-2:0] m;
    logic [PW-1:0] p;
    logic [TW-1:0] t;
    logic [BYTE_W-1:0] res;
    m = blend[BW-2:0];
    p = {m, 8'h00} - PW'(m);
    t = p[PW-1:SH];
    if (blend[BW-1] || (m == '0)) begin
      res = '0;
    end else if (t > BYTE_MAX_T) begin
      res = BYTE_MAX;
    end else begin
      res = t[BYTE_W-1:0];
    end
    return res;
  endfunction

  // stage f: result register
  logic              vf_r;
  logic [BYTE_W-1:0] red_r, green_r, blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else begin
      vf_r <= bl_valid;
    end
  end

  always_ff @(posedge clk) begin
    red_r   <= to_byte(bl_r);
    green_r <= to_byte(bl_g);
    blue_r  <= to_byte(bl_b);
  end

  assign out_valid = vf_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule

### src/hsv_to_rgb_led_color.sv
// Converts a hue and saturation into three led color bytes, scaled by brightness.
//
// Input: a transfer happens on a rising edge with start high and busy low.
// busy is always low, so a new hue/saturation pair may be given every cycle.
// Output: out_valid pulses for one cycle with the three bytes of one result;
// the receiver cannot stall, results are never held or dropped.
// Each input transfer passes through a six-stage pipeline (sector split,
// brightness multiply, channel sum, saturation multiply, blend add, byte
// scaling), each stage one register deep. Throughput: one item per cycle.
// Configuration: cfg_we writes cfg_wdata into brightness (q8, 256 is 1.0).
// Write only while no item is in flight; it is used directly by the
// brightness multiply stage.
// Reset (rst_n low, synchronous): brightness returns to 256 and all pipeline
// valid bits clear, so items in flight are discarded.
// Hue uses the low HUE_BITS bits of in_hue_turns as a fraction of one turn.
`timescale 1ns / 1ps

module hsv_to_rgb_led_color
  import hsvl_pkg::*;
#(
  parameter int HUE_BITS = HUE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [HUE_W-1:0]  in_hue_turns,
  input  logic [SAT_W-1:0]  in_saturation,
  input  logic              cfg_we,
  input  logic [BRI_W-1:0]  cfg_wdata,
  output logic              out_valid,
  output logic [BYTE_W-1:0] out_red_byte,
  output logic [BYTE_W-1:0] out_blue_byte,
  output logic [BYTE_W-1:0] out_green_byte
);

  localparam int HB = HUE_BITS;
  localparam int PW = HB + BRI_W + 1;
  localparam int BW = HB + 23;

  // brightness register
  logic [BRI_W-1:0] brightness_r, brightness_nxt;

  assign brightness_nxt = cfg_we ? cfg_wdata : brightness_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= BRI_RESET;
    end else begin
      brightness_r <= brightness_nxt;
    end
  end

  // fully pipelined, never stalls
  logic in_xfer;

  assign busy    = 1'b0;
  assign in_xfer = start && !busy;

  // sector split and channel levels
  logic             lvl_valid;
  logic [PW-1:0]    lvl_r, lvl_g, lvl_b;
  logic [SAT_W-1:0] lvl_sat;

  hsvl_sector #(
    .HUE_BITS (HB)
  ) u_sector (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_xfer),
    .in_hue     (in_hue_turns),
    .in_sat     (in_saturation),
    .brightness (brightness_r),
    .lvl_valid  (lvl_valid),
    .lvl_r      (lvl_r),
    .lvl_g      (lvl_g),
    .lvl_b      (lvl_b),
    .lvl_sat    (lvl_sat)
  );

  // saturation blend
  logic                 bl_valid;
  logic signed [BW-1:0] bl_r, bl_g, bl_b;

  hsvl_blend #(
    .HUE_BITS (HB)
  ) u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .lvl_valid (lvl_valid),
    .lvl_r     (lvl_r),
    .lvl_g     (lvl_g),
    .lvl_b     (lvl_b),
    .lvl_sat   (lvl_sat),
    .bl_valid  (bl_valid),
    .bl_r      (bl_r),
    .bl_g      (bl_g),
    .bl_b      (bl_b)
  );

  // byte scaling and result register
  hsvl_byte #(
    .HUE_BITS (HB)
  ) u_byte (
    .clk       (clk),
    .rst_n     (rst_n),
    .bl_valid  (bl_valid),
    .bl_r      (bl_r),
    .bl_g      (bl_g),
    .bl_b      (bl_b),
    .out_valid (out_valid),
    .out_red   (out_red_byte),
    .out_green (out_green_byte),
    .out_blue  (out_blue_byte)
  );

`ifndef NO_ASSERTIONS
  // every input transfer produces a result strobe after the pipeline latency
  a_xfer_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> ##PIPE_LAT out_valid)
    else $error("input transfer without result");

  // no result strobe without a matching input transfer
  a_result_from_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_xfer, PIPE_LAT))
    else $error("result without input transfer");

  // zero saturation gives equal bytes on all three channels, each taken from the channel sum
  a_gray_on_zero_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ($past(in_saturation, PIPE_LAT) == '0))
      |-> ((out_red_byte == out_blue_byte) && (out_blue_byte == out_green_byte)))
    else $error("unequal bytes at zero saturation");

  // zero brightness gives black
  a_black_on_zero_bri: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (brightness_r == '0))
      |-> ((out_red_byte == '0) && (out_blue_byte == '0) && (out_green_byte == '0)))
    else $error("nonzero byte at zero brightness");
`endif

endmodule
